// ===== hdl/mclp_pkg.sv =====
package mclp_pkg;

    localparam int FIELD_CHARS_DEF = 5;
    localparam int LEN_W           = 3;
    localparam int ACC_W           = 16;

    typedef enum logic [1:0] {
        LM_LISTEN   = 2'd0,
        LM_NUMBER   = 2'd1,
        LM_COMMAND  = 2'd2,
        LM_CONFUSED = 2'd3
    } line_mode_t;

    typedef enum logic [3:0] {
        ACT_NONE     = 4'd0,
        ACT_SET_POS  = 4'd1,
        ACT_SET_VEL  = 4'd2,
        ACT_POS_MODE = 4'd3,
        ACT_VEL_MODE = 4'd4,
        ACT_STATUS   = 4'd5,
        ACT_STOP     = 4'd6,
        ACT_BRAKE    = 4'd7,
        ACT_INFO     = 4'd8
    } action_t;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_P_LO   = 8'h70;
    localparam logic [7:0] CH_P_UP   = 8'h50;
    localparam logic [7:0] CH_V_LO   = 8'h76;
    localparam logic [7:0] CH_V_UP   = 8'h56;
    localparam logic [7:0] CH_S_LO   = 8'h73;
    localparam logic [7:0] CH_S_UP   = 8'h53;
    localparam logic [7:0] CH_K_LO   = 8'h6B;
    localparam logic [7:0] CH_K_UP   = 8'h4B;
    localparam logic [7:0] CH_B_LO   = 8'h62;
    localparam logic [7:0] CH_B_UP   = 8'h42;
    localparam logic [7:0] CH_I_LO   = 8'h69;
    localparam logic [7:0] CH_I_UP   = 8'h49;
    localparam logic [7:0] CH_D_LO   = 8'h64;

    typedef struct packed {
        line_mode_t         line_mode;
        logic [LEN_W-1:0]   field_length;
        logic [7:0]         lead_char;
        logic [ACC_W-1:0]   accumulator;
        logic               vel_mode;
    } parse_state_t;

    typedef struct packed {
        action_t            action;
        logic [ACC_W-1:0]   value;
    } parse_result_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_field_char(input logic [7:0] c);
        return is_digit(c) || (c == CH_PLUS) || (c == CH_MINUS) ||
               (c == CH_P_LO) || (c == CH_D_LO) || (c == CH_I_LO);
    endfunction

endpackage

// ===== hdl/mclp_step.sv =====
// Next state and result for one received character.
module mclp_step #(
    parameter int FIELD_CHARS = mclp_pkg::FIELD_CHARS_DEF
) (
    input  logic [7:0]              rx_char,
    input  mclp_pkg::parse_state_t  cur,
    output mclp_pkg::parse_state_t  nxt,
    output mclp_pkg::parse_result_t res
);

    logic                        line_end;
    logic [mclp_pkg::ACC_W-1:0]  acc_base;
    logic [mclp_pkg::LEN_W-1:0]  len_base;

    assign line_end = (rx_char == mclp_pkg::CH_CR) || (rx_char == mclp_pkg::CH_LF);

    always_comb
    begin
        nxt        = cur;
        res.action = mclp_pkg::ACT_NONE;
        res.value  = '0;
        acc_base   = cur.accumulator;
        len_base   = cur.field_length;

        case (cur.line_mode)
            mclp_pkg::LM_CONFUSED:
            begin
                if (line_end)
                    nxt.line_mode = mclp_pkg::LM_LISTEN;
            end
            mclp_pkg::LM_COMMAND:
            begin
                nxt.line_mode = mclp_pkg::LM_LISTEN;
                case (rx_char)
                    mclp_pkg::CH_P_LO, mclp_pkg::CH_P_UP:
                    begin
                        nxt.vel_mode = 1'b0;
                        res.action   = mclp_pkg::ACT_POS_MODE;
                    end
                    mclp_pkg::CH_V_LO, mclp_pkg::CH_V_UP:
                    begin
                        nxt.vel_mode = 1'b1;
                        res.action   = mclp_pkg::ACT_VEL_MODE;
                    end
                    mclp_pkg::CH_S_LO, mclp_pkg::CH_S_UP: res.action = mclp_pkg::ACT_STATUS;
                    mclp_pkg::CH_K_LO, mclp_pkg::CH_K_UP: res.action = mclp_pkg::ACT_STOP;
                    mclp_pkg::CH_B_LO, mclp_pkg::CH_B_UP: res.action = mclp_pkg::ACT_BRAKE;
                    mclp_pkg::CH_I_LO, mclp_pkg::CH_I_UP: res.action = mclp_pkg::ACT_INFO;
                    default: res.action = mclp_pkg::ACT_NONE;
                endcase
            end
            default:
            begin
                // listen or number
                if (mclp_pkg::is_field_char(rx_char))
                begin
                    if (cur.line_mode == mclp_pkg::LM_LISTEN)
                    begin
                        nxt.line_mode = mclp_pkg::LM_NUMBER;
                        acc_base      = '0;
                        len_base      = '0;
                    end
                    nxt.accumulator  = acc_base;
                    nxt.field_length = len_base;
                    if (len_base >= mclp_pkg::LEN_W'(FIELD_CHARS))
                        nxt.line_mode = mclp_pkg::LM_CONFUSED;
                    else
                    begin
                        if (len_base == '0)
                            nxt.lead_char = rx_char;
                        // acc * 10 + digit, wrapping at 16 bits
                        if (mclp_pkg::is_digit(rx_char))
                            nxt.accumulator = (acc_base << 3) + (acc_base << 1) +
                                              {{(mclp_pkg::ACC_W-4){1'b0}}, rx_char[3:0]};
                        nxt.field_length = len_base + 1'b1;
                    end
                end
                else if (line_end)
                begin
                    if ((cur.line_mode == mclp_pkg::LM_NUMBER) &&
                        ((cur.lead_char == mclp_pkg::CH_PLUS) ||
                         (cur.lead_char == mclp_pkg::CH_MINUS)))
                    begin
                        res.value  = (cur.lead_char == mclp_pkg::CH_MINUS) ?
                                     ('0 - cur.accumulator) : cur.accumulator;
                        res.action = cur.vel_mode ? mclp_pkg::ACT_SET_VEL
                                                  : mclp_pkg::ACT_SET_POS;
                    end
                    nxt.line_mode = mclp_pkg::LM_LISTEN;
                end
                else if (rx_char == mclp_pkg::CH_BSLASH)
                    nxt.line_mode = (cur.line_mode == mclp_pkg::LM_LISTEN) ?
                                    mclp_pkg::LM_COMMAND : mclp_pkg::LM_CONFUSED;
                else
                    nxt.line_mode = mclp_pkg::LM_CONFUSED;
            end
        endcase
    end

endmodule

// ===== hdl/motor_command_line_parser_core.sv =====
// Motor command line parser core.
// Input channel: one received byte per transfer on rx_char (in_valid/in_ready).
// Output channel: one result per input transfer (out_valid/out_ready): the
// echoed byte, an action code, a 16-bit target for the set actions (two's
// complement for negative numbers, 0 otherwise) and the motor mode after it.
// Backslash plus letter selects mode or asks for status/stop/brake/info;
// a signed number of up to FIELD_CHARS characters ended by CR or LF sets
// position or velocity, depending on the current mode.
// Timing: the result is registered in the output register and appears in the
// cycle after the input transfer. Throughput: one character per cycle while
// results are taken, as the parser state update feeds straight back on itself.
// Reset: parser returns to listen, field cleared, position mode, output
// register empty.
// Stall: while the output register holds an untaken result, in_ready is
// low; once out_ready is high a new character is taken in the same cycle.
module motor_command_line_parser_core #(
    parameter int FIELD_CHARS = mclp_pkg::FIELD_CHARS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_char,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  echo_char,
    output logic [3:0]  action,
    output logic [15:0] value,
    output logic        velocity_mode
);

    mclp_pkg::parse_state_t  state_reg;
    mclp_pkg::parse_state_t  state_next;
    mclp_pkg::parse_result_t res_next;
    mclp_pkg::parse_result_t res_reg;
    logic [7:0]              echo_reg;
    logic                    mode_reg;
    logic                    out_valid_reg;
    logic                    in_xfer;

    // Output register frees up in the cycle it is taken.
    assign in_ready = !out_valid_reg || out_ready;
    assign in_xfer  = in_valid && in_ready;

    mclp_step #(
        .FIELD_CHARS (FIELD_CHARS)
    ) u_step (
        .rx_char (rx_char),
        .cur     (state_reg),
        .nxt     (state_next),
        .res     (res_next)
    );

    // Parser state and output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.line_mode    <= mclp_pkg::LM_LISTEN;
            state_reg.field_length <= '0;
            state_reg.lead_char    <= '0;
            state_reg.accumulator  <= '0;
            state_reg.vel_mode     <= 1'b0;
            out_valid_reg          <= 1'b0;
        end
        else
        begin
            if (in_xfer)
                state_reg <= state_next;
            if (in_xfer)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload, loaded on each input transfer.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            res_reg  <= res_next;
            echo_reg <= rx_char;
            mode_reg <= state_next.vel_mode;
        end
    end

    assign out_valid     = out_valid_reg;
    assign echo_char     = echo_reg;
    assign action        = res_reg.action;
    assign value         = res_reg.value;
    assign velocity_mode = mode_reg;

    // A set-position result is only ever issued in position mode.
    a_setpos_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (action == mclp_pkg::ACT_SET_POS)) |-> !velocity_mode)
        else $error("set position issued in velocity mode");

    // Only set actions carry a non-zero target.
    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (action != mclp_pkg::ACT_SET_POS) &&
         (action != mclp_pkg::ACT_SET_VEL)) |-> (value == '0))
        else $error("non-set action with non-zero value");

    // Field never grows past its limit.
    a_field_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.field_length <= mclp_pkg::LEN_W'(FIELD_CHARS))
        else $error("field length beyond limit");

    // The echoed byte is the one taken in the previous cycle.
    a_echo: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (out_valid && (echo_char == $past(rx_char))))
        else $error("echo does not match accepted byte");

    // A velocity-mode select leaves the block in velocity mode.
    a_velmode: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (action == mclp_pkg::ACT_VEL_MODE)) |-> velocity_mode)
        else $error("velocity mode select not reflected");

endmodule
